// ----- rtl/core/time_window_aggregator_core_defines.svh -----
// Assertion macros for the time window aggregator checker.
// No dependencies; included by the checker file only.
`ifndef TIME_WINDOW_AGGREGATOR_CORE_DEFINES_SVH
`define TIME_WINDOW_AGGREGATOR_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TWA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define TWA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/twa_pkg.sv -----
// Shared widths, codes and controller/datapath interface types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package twa_pkg;

    localparam int STAMP_BITS  = 48;
    localparam int SAMPLE_BITS = 24;
    localparam int COUNT_BITS  = 16;
    localparam int SUM_BITS    = 40;
    localparam int SQ_BITS     = 63;
    localparam int PROD_BITS   = 80;
    localparam int RES_BITS    = 48;
    localparam int CFG_BITS    = 48;
    localparam int ENG_CNT_W   = 7;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // iteration counts of the shared engine
    localparam logic [ENG_CNT_W-1:0] STEPS_ALIGN = ENG_CNT_W'(STAMP_BITS);
    localparam logic [ENG_CNT_W-1:0] STEPS_AVG   = ENG_CNT_W'(SUM_BITS);
    localparam logic [ENG_CNT_W-1:0] STEPS_MNSQ  = ENG_CNT_W'(COUNT_BITS);
    localparam logic [ENG_CNT_W-1:0] STEPS_MSS   = ENG_CNT_W'(SUM_BITS);
    localparam logic [ENG_CNT_W-1:0] STEPS_VDIV  = ENG_CNT_W'(PROD_BITS);
    localparam logic [ENG_CNT_W-1:0] STEPS_SQRT  = ENG_CNT_W'(32);

    // configuration register indexes
    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_LENGTH = 2'd1;
    localparam logic [1:0] CFG_GAP    = 2'd2;
    localparam logic [1:0] CFG_KIND   = 2'd3;

    // aggregate kinds
    localparam logic [2:0] AGG_SUM   = 3'd0;
    localparam logic [2:0] AGG_AVG   = 3'd1;
    localparam logic [2:0] AGG_MIN   = 3'd2;
    localparam logic [2:0] AGG_MAX   = 3'd3;
    localparam logic [2:0] AGG_COUNT = 3'd4;
    localparam logic [2:0] AGG_FIRST = 3'd5;
    localparam logic [2:0] AGG_LAST  = 3'd6;
    localparam logic [2:0] AGG_STD   = 3'd7;

    // datapath commands
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_CAPTURE  = 4'd1;
    localparam logic [3:0] OP_ALIGN    = 4'd2;
    localparam logic [3:0] OP_DECIDE   = 4'd3;
    localparam logic [3:0] OP_AVG      = 4'd4;
    localparam logic [3:0] OP_MUL_NSQ  = 4'd5;
    localparam logic [3:0] OP_MUL_SS   = 4'd6;
    localparam logic [3:0] OP_DIV_VAR  = 4'd7;
    localparam logic [3:0] OP_SQRT     = 4'd8;
    localparam logic [3:0] OP_EMIT     = 4'd9;
    localparam logic [3:0] OP_UPDATE   = 4'd10;

    // engine modes
    localparam logic [1:0] ENG_DIV  = 2'd0;
    localparam logic [1:0] ENG_MUL  = 2'd1;
    localparam logic [1:0] ENG_SQRT = 2'd2;

    typedef struct packed {
        logic [3:0] op;
        logic       closes;
        logic       final_res;
    } t_dp_cmd;

    typedef struct packed {
        logic       busy;
        logic       win_open;
        logic       same;
        logic       out_busy;
        logic       mode;
        logic [2:0] kind;
        logic       item_last;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- rtl/core/time_window_aggregator_core.sv -----
// Channel    | dir | signals                         | content
// s_axis     | in  | tdata[71:0], tlast              | stamp, sample; tlast = batch_end
// m_axis     | out | tdata[111:0], tuser[1:0], tlast | start, agg, count; sat, final; closes
// cfg        | in  | we, addr[1:0], wdata[47:0]      | mode, length, gap, agg kind
//
// One beat at a time, ready only while idle; in tumbling mode a beat also waits on
// the 48-step alignment divide.
// A window close waits on the 40-step divide for avg, or for stddev on the 16- and
// 40-step multiplies, an 80-step divide and a 32-step root, all on one shared engine.
// A batch end adds one more close for the flush.
// Synchronous active-low reset; no clearing pass. A held result stalls the next close only.
// Top level; depends on twa_pkg, twa_ctrl and twa_datapath.
`timescale 1ns / 1ps
`default_nettype none

module time_window_aggregator_core
    import twa_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  wire logic [71:0]          i_s_axis_tdata,   // stamp[47:0], sample[71:48]
    input  wire logic                 i_s_axis_tlast,   // batch_end
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    output logic [111:0]              o_m_axis_tdata,   // win_start, agg_result, point_count
    output logic [1:0]                o_m_axis_tuser,   // saturated, final_of_item
    output logic                      o_m_axis_tlast,   // closes_batch
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_addr,
    input  wire logic [CFG_BITS-1:0]  i_cfg_wdata
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    twa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    twa_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_stamp         (i_s_axis_tdata[STAMP_BITS-1:0]),
        .i_sample        (i_s_axis_tdata[STAMP_BITS+SAMPLE_BITS-1:STAMP_BITS]),
        .i_batch_end     (i_s_axis_tlast),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_out_ready     (i_m_axis_tready),
        .o_out_valid     (o_m_axis_tvalid),
        .o_win_start     (o_m_axis_tdata[47:0]),
        .o_agg_result    (o_m_axis_tdata[95:48]),
        .o_point_count   (o_m_axis_tdata[111:96]),
        .o_saturated     (o_m_axis_tuser[0]),
        .o_closes_batch  (o_m_axis_tlast),
        .o_final_of_item (o_m_axis_tuser[1])
    );

endmodule

`default_nettype wire

// ----- rtl/core/twa_ctrl.sv -----
// Sequencer for the window aggregator: accepts beats and steps the datapath.
// Depends on twa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module twa_ctrl
    import twa_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    localparam logic [4:0] S_IDLE       = 5'd0;
    localparam logic [4:0] S_ALIGN_GO   = 5'd1;
    localparam logic [4:0] S_ALIGN_WAIT = 5'd2;
    localparam logic [4:0] S_DECIDE     = 5'd3;
    localparam logic [4:0] S_CHOOSE     = 5'd4;
    localparam logic [4:0] S_AGG        = 5'd5;
    localparam logic [4:0] S_AVG_GO     = 5'd6;
    localparam logic [4:0] S_AVG_WAIT   = 5'd7;
    localparam logic [4:0] S_MUL1_GO    = 5'd8;
    localparam logic [4:0] S_MUL1_WAIT  = 5'd9;
    localparam logic [4:0] S_MUL2_GO    = 5'd10;
    localparam logic [4:0] S_MUL2_WAIT  = 5'd11;
    localparam logic [4:0] S_VAR_GO     = 5'd12;
    localparam logic [4:0] S_VAR_WAIT   = 5'd13;
    localparam logic [4:0] S_SQRT_GO    = 5'd14;
    localparam logic [4:0] S_SQRT_WAIT  = 5'd15;
    localparam logic [4:0] S_EMIT       = 5'd16;
    localparam logic [4:0] S_UPDATE     = 5'd17;

    logic [4:0] r_state, n_state;
    logic       r_phase, n_phase;   // 1 while flushing on batch end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_phase          = r_phase;
        o_in_ready       = 1'b0;
        o_cmd.op         = OP_NONE;
        o_cmd.closes     = 1'b0;
        o_cmd.final_res  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_CAPTURE;
                    n_phase  = 1'b0;
                    n_state  = i_stat.mode ? S_DECIDE : S_ALIGN_GO;
                end
            end
            S_ALIGN_GO: begin
                o_cmd.op = OP_ALIGN;
                n_state  = S_ALIGN_WAIT;
            end
            S_ALIGN_WAIT: if (!i_stat.busy) n_state = S_DECIDE;
            S_DECIDE: begin
                o_cmd.op = OP_DECIDE;
                n_state  = S_CHOOSE;
            end
            S_CHOOSE: begin
                if (!i_stat.win_open || i_stat.same) n_state = S_UPDATE;
                else n_state = S_AGG;
            end
            S_AGG: begin
                case (i_stat.kind)
                    AGG_AVG: n_state = S_AVG_GO;
                    AGG_STD: n_state = S_MUL1_GO;
                    default: n_state = S_EMIT;
                endcase
            end
            S_AVG_GO: begin
                o_cmd.op = OP_AVG;
                n_state  = S_AVG_WAIT;
            end
            S_AVG_WAIT: if (!i_stat.busy) n_state = S_EMIT;
            S_MUL1_GO: begin
                o_cmd.op = OP_MUL_NSQ;
                n_state  = S_MUL1_WAIT;
            end
            S_MUL1_WAIT: if (!i_stat.busy) n_state = S_MUL2_GO;
            S_MUL2_GO: begin
                o_cmd.op = OP_MUL_SS;
                n_state  = S_MUL2_WAIT;
            end
            S_MUL2_WAIT: if (!i_stat.busy) n_state = S_VAR_GO;
            S_VAR_GO: begin
                o_cmd.op = OP_DIV_VAR;
                n_state  = S_VAR_WAIT;
            end
            S_VAR_WAIT: if (!i_stat.busy) n_state = S_SQRT_GO;
            S_SQRT_GO: begin
                o_cmd.op = OP_SQRT;
                n_state  = S_SQRT_WAIT;
            end
            S_SQRT_WAIT: if (!i_stat.busy) n_state = S_EMIT;
            S_EMIT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op        = OP_EMIT;
                    o_cmd.closes    = r_phase;
                    o_cmd.final_res = r_phase | ~i_stat.item_last;
                    n_state         = r_phase ? S_IDLE : S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.op = OP_UPDATE;
                if (i_stat.item_last) begin
                    n_phase = 1'b1;
                    n_state = S_AGG;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/twa_datapath.sv -----
// Window state, config registers, shared divide/multiply/sqrt engine, output register.
// Depends on twa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module twa_datapath
    import twa_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [1:0]                    i_cfg_addr,
    input  wire logic [CFG_BITS-1:0]           i_cfg_wdata,
    input  wire logic [STAMP_BITS-1:0]         i_stamp,
    input  wire logic [SAMPLE_BITS-1:0]        i_sample,
    input  wire logic                          i_batch_end,
    input  wire t_dp_cmd                       i_cmd,
    output t_dp_stat                           o_stat,
    input  wire logic                          i_out_ready,
    output logic                               o_out_valid,
    output logic [STAMP_BITS-1:0]              o_win_start,
    output logic [RES_BITS-1:0]                o_agg_result,
    output logic [COUNT_BITS-1:0]              o_point_count,
    output logic                               o_saturated,
    output logic                               o_closes_batch,
    output logic                               o_final_of_item
);

    // configuration
    logic                   r_mode;
    logic [CFG_BITS-1:0]    r_len, r_gap;
    logic [2:0]             r_kind;
    // current item
    logic [STAMP_BITS-1:0]  r_stamp;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic                   r_last;
    // window state
    logic                   r_open, r_drop, r_same;
    logic [STAMP_BITS-1:0]  r_start, r_prev, r_align;
    logic [SUM_BITS-1:0]    r_sum;
    logic [SQ_BITS-1:0]     r_sumsq;
    logic [COUNT_BITS-1:0]  r_count;
    logic [SAMPLE_BITS-1:0] r_min, r_max, r_first, r_latest;
    // engine
    logic [1:0]             r_eng_mode;
    logic [ENG_CNT_W-1:0]   r_eng_cnt;
    logic [PROD_BITS-1:0]   r_acc, r_a, r_prod;
    logic [63:0]            r_b;
    logic [STAMP_BITS-1:0]  r_rem, r_div;
    logic                   r_neg;
    // output register
    logic                   r_out_valid, r_o_sat, r_o_closes, r_o_final;
    logic [STAMP_BITS-1:0]  r_o_start;
    logic [RES_BITS-1:0]    r_o_agg;
    logic [COUNT_BITS-1:0]  r_o_cnt;

    logic [SAMPLE_BITS-1:0]   w_mag;
    logic [2*SAMPLE_BITS-1:0] w_sq;
    logic [SUM_BITS-1:0]      w_sum_mag, w_sum_ext;
    logic [2*COUNT_BITS-1:0]  w_nsq;
    logic [PROD_BITS-1:0]     w_diff;
    logic                     w_lt;
    logic [STAMP_BITS-1:0]    w_gap, w_align;
    logic [STAMP_BITS:0]      w_t, w_tsub;
    logic                     w_ge;
    logic [PROD_BITS-1:0]     w_acc_add;
    logic [63:0]              w_rb, w_sq_in;
    logic                     w_rb_ge;
    logic [RES_BITS-1:0]      w_q48, w_agg;
    logic                     w_new;

    assign w_mag     = r_sample[SAMPLE_BITS-1] ? (~r_sample + 1'b1) : r_sample;
    assign w_sq      = w_mag * w_mag;
    assign w_sum_mag = r_sum[SUM_BITS-1] ? (~r_sum + 1'b1) : r_sum;
    assign w_sum_ext = {{(SUM_BITS-SAMPLE_BITS){r_sample[SAMPLE_BITS-1]}}, r_sample};
    assign w_nsq     = r_count * r_count;
    assign w_lt      = r_prod < r_acc;
    assign w_diff    = r_prod - r_acc;
    assign w_gap     = (r_stamp >= r_prev) ? (r_stamp - r_prev) : '0;
    assign w_align   = r_stamp - r_rem;
    // restoring divide step
    assign w_t       = {r_rem, r_a[PROD_BITS-1]};
    assign w_ge      = w_t >= {1'b0, r_div};
    assign w_tsub    = w_t - {1'b0, r_div};
    // shift-add multiply step
    assign w_acc_add = r_acc + r_a;
    // digit-by-digit square root step: x in r_acc, root in r_a, bit in r_b
    assign w_rb      = r_a[63:0] + r_b;
    assign w_rb_ge   = r_acc[63:0] >= w_rb;
    // quotient above 64 bits saturates
    assign w_sq_in   = r_neg ? 64'd0 :
                       ((r_a[PROD_BITS-1:64] != '0) ? {64{1'b1}} : r_a[63:0]);
    assign w_new     = !r_open || !r_same;

    assign w_q48 = {{(RES_BITS-SUM_BITS){1'b0}}, r_a[SUM_BITS-1:0]};

    always_comb begin
        case (r_kind)
            AGG_SUM:   w_agg = {{(RES_BITS-SUM_BITS){r_sum[SUM_BITS-1]}}, r_sum};
            AGG_AVG:   w_agg = r_sum[SUM_BITS-1] ? (~w_q48 + 1'b1) : w_q48;
            AGG_MIN:   w_agg = {{(RES_BITS-SAMPLE_BITS){r_min[SAMPLE_BITS-1]}}, r_min};
            AGG_MAX:   w_agg = {{(RES_BITS-SAMPLE_BITS){r_max[SAMPLE_BITS-1]}}, r_max};
            AGG_COUNT: w_agg = {{(RES_BITS-COUNT_BITS){1'b0}}, r_count};
            AGG_FIRST: w_agg = {{(RES_BITS-SAMPLE_BITS){r_first[SAMPLE_BITS-1]}}, r_first};
            AGG_LAST:  w_agg = {{(RES_BITS-SAMPLE_BITS){r_latest[SAMPLE_BITS-1]}}, r_latest};
            default:   w_agg = r_a[RES_BITS-1:0];
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_len  <= CFG_BITS'(60000);
            r_gap  <= CFG_BITS'(30000);
            r_kind <= AGG_AVG;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MODE:   r_mode <= i_cfg_wdata[0];
                CFG_LENGTH: r_len  <= i_cfg_wdata;
                CFG_GAP:    r_gap  <= i_cfg_wdata;
                CFG_KIND:   r_kind <= i_cfg_wdata[2:0];
                default:    r_mode <= r_mode;
            endcase
        end
    end

    // item capture and decision
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_CAPTURE) begin
            r_stamp  <= i_stamp;
            r_sample <= i_sample;
            r_last   <= i_batch_end;
        end
        if (i_cmd.op == OP_DECIDE) begin
            r_align <= w_align;
            r_same  <= r_mode ? (w_gap <= r_gap) : (w_align == r_start);
        end
    end

    // window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_cmd.op == OP_EMIT && i_cmd.closes)) begin
            r_open   <= 1'b0;
            r_start  <= '0;
            r_prev   <= '0;
            r_sum    <= '0;
            r_sumsq  <= '0;
            r_count  <= '0;
            r_min    <= '0;
            r_max    <= '0;
            r_first  <= '0;
            r_latest <= '0;
            r_drop   <= 1'b0;
        end else if (i_cmd.op == OP_UPDATE) begin
            r_prev <= r_stamp;
            if (w_new) begin
                r_open   <= 1'b1;
                r_start  <= r_mode ? r_stamp : r_align;
                r_sum    <= w_sum_ext;
                r_sumsq  <= SQ_BITS'(w_sq);
                r_count  <= COUNT_BITS'(1);
                r_min    <= r_sample;
                r_max    <= r_sample;
                r_first  <= r_sample;
                r_latest <= r_sample;
                r_drop   <= 1'b0;
            end else if (r_count == COUNT_MAX) begin
                r_drop <= 1'b1;
            end else begin
                r_sum    <= r_sum + w_sum_ext;
                r_sumsq  <= r_sumsq + SQ_BITS'(w_sq);
                r_count  <= r_count + 1'b1;
                if ($signed(r_sample) < $signed(r_min)) r_min <= r_sample;
                if ($signed(r_sample) > $signed(r_max)) r_max <= r_sample;
                r_latest <= r_sample;
            end
        end
    end

    // shared iterative engine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eng_cnt <= '0;
        end else begin
            case (i_cmd.op)
                OP_ALIGN: begin
                    r_eng_mode <= ENG_DIV;
                    r_a        <= {r_stamp, {(PROD_BITS-STAMP_BITS){1'b0}}};
                    r_rem      <= '0;
                    r_div      <= (r_len == '0) ? STAMP_BITS'(1) : r_len;
                    r_eng_cnt  <= STEPS_ALIGN;
                end
                OP_AVG: begin
                    r_eng_mode <= ENG_DIV;
                    r_a        <= {w_sum_mag, {(PROD_BITS-SUM_BITS){1'b0}}};
                    r_rem      <= '0;
                    r_div      <= {{(STAMP_BITS-COUNT_BITS){1'b0}}, r_count};
                    r_eng_cnt  <= STEPS_AVG;
                end
                OP_MUL_NSQ: begin
                    r_eng_mode <= ENG_MUL;
                    r_acc      <= '0;
                    r_a        <= {{(PROD_BITS-SQ_BITS){1'b0}}, r_sumsq};
                    r_b        <= {{(64-COUNT_BITS){1'b0}}, r_count};
                    r_eng_cnt  <= STEPS_MNSQ;
                end
                OP_MUL_SS: begin
                    r_eng_mode <= ENG_MUL;
                    r_prod     <= r_acc;
                    r_acc      <= '0;
                    r_a        <= {{(PROD_BITS-SUM_BITS){1'b0}}, w_sum_mag};
                    r_b        <= {{(64-SUM_BITS){1'b0}}, w_sum_mag};
                    r_eng_cnt  <= STEPS_MSS;
                end
                OP_DIV_VAR: begin
                    r_eng_mode <= ENG_DIV;
                    r_neg      <= w_lt;
                    r_a        <= w_diff;
                    r_rem      <= '0;
                    r_div      <= {{(STAMP_BITS-2*COUNT_BITS){1'b0}}, w_nsq};
                    r_eng_cnt  <= STEPS_VDIV;
                end
                OP_SQRT: begin
                    r_eng_mode <= ENG_SQRT;
                    r_acc      <= {{(PROD_BITS-64){1'b0}}, w_sq_in};
                    r_a        <= '0;
                    r_b        <= 64'h4000_0000_0000_0000;
                    r_eng_cnt  <= STEPS_SQRT;
                end
                default: begin
                    if (r_eng_cnt != '0) begin
                        r_eng_cnt <= r_eng_cnt - 1'b1;
                        case (r_eng_mode)
                            ENG_DIV: begin
                                r_rem <= w_ge ? w_tsub[STAMP_BITS-1:0] : w_t[STAMP_BITS-1:0];
                                r_a   <= {r_a[PROD_BITS-2:0], w_ge};
                            end
                            ENG_MUL: begin
                                if (r_b[0]) r_acc <= w_acc_add;
                                r_a <= {r_a[PROD_BITS-2:0], 1'b0};
                                r_b <= {1'b0, r_b[63:1]};
                            end
                            default: begin
                                if (w_rb_ge) begin
                                    r_acc <= {{(PROD_BITS-64){1'b0}}, r_acc[63:0] - w_rb};
                                    r_a   <= {{(PROD_BITS-64){1'b0}},
                                              ({1'b0, r_a[63:1]} + r_b)};
                                end else begin
                                    r_a   <= {{(PROD_BITS-64){1'b0}}, 1'b0, r_a[63:1]};
                                end
                                r_b <= {2'b00, r_b[63:2]};
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.op == OP_EMIT) begin
            r_o_start  <= r_start;
            r_o_agg    <= w_agg;
            r_o_cnt    <= r_count;
            r_o_sat    <= r_drop;
            r_o_closes <= i_cmd.closes;
            r_o_final  <= i_cmd.final_res;
        end
    end

    assign o_stat.busy      = r_eng_cnt != '0;
    assign o_stat.win_open  = r_open;
    assign o_stat.same      = r_same;
    assign o_stat.out_busy  = r_out_valid;
    assign o_stat.mode      = r_mode;
    assign o_stat.kind      = r_kind;
    assign o_stat.item_last = r_last;

    assign o_out_valid     = r_out_valid;
    assign o_win_start     = r_o_start;
    assign o_agg_result    = r_o_agg;
    assign o_point_count   = r_o_cnt;
    assign o_saturated     = r_o_sat;
    assign o_closes_batch  = r_o_closes;
    assign o_final_of_item = r_o_final;

endmodule

`default_nettype wire

// ----- rtl/core/twa_checker.sv -----
// Port-level checks for the window aggregator, bound to the top level.
// Depends on time_window_aggregator_core_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "time_window_aggregator_core_defines.svh"

module twa_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         i_s_axis_tvalid,
    input wire logic         o_s_axis_tready,
    input wire logic         o_m_axis_tvalid,
    input wire logic         i_m_axis_tready,
    input wire logic [111:0] o_m_axis_tdata,
    input wire logic [1:0]   o_m_axis_tuser,
    input wire logic         o_m_axis_tlast
);

    `TWA_ASSERT_NEXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "result beat dropped or changed while stalled")
    `TWA_ASSERT_IMPL(a_count_nonzero, o_m_axis_tvalid, o_m_axis_tdata[111:96] != 16'd0, "window emitted with no points")
    `TWA_ASSERT_IMPL(a_close_is_final, o_m_axis_tvalid && o_m_axis_tlast, o_m_axis_tuser[1], "batch flush not marked final")
    `TWA_ASSERT_IMPL(a_sat_full, o_m_axis_tvalid && o_m_axis_tuser[0], o_m_axis_tdata[111:96] == 16'hFFFF, "saturated below count limit")
    `TWA_ASSERT_NEXT(a_in_single, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "input beat taken while busy")

endmodule

bind time_window_aggregator_core twa_checker u_twa_checker (.*);

`default_nettype wire
